// ===== src/bsbi_pkg.sv =====
// ---------------------------------------------------------------------------
// bsbi_pkg: shared types and constants for the bounded stack
// Item layouts, operation and status codes, and the per-cell control group.
// ---------------------------------------------------------------------------
package bsbi_pkg;

  localparam int STK_DEPTH = 16;
  localparam int WORD_W    = 32;
  localparam int FILL_W    = 5;

  localparam logic signed [WORD_W-1:0] EMPTY_READ = '1;

  typedef enum logic [1:0] {
    OP_PUSH_TOP    = 2'd0,
    OP_PUSH_BOTTOM = 2'd1,
    OP_POP         = 2'd2,
    OP_PEEK        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    status_t                  status;
    logic [FILL_W-1:0]        fill_count;
    logic                     is_empty;
  } out_item_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic push_top;
    logic push_bot;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== src/bsbi_cell.sv =====
// ---------------------------------------------------------------------------
// bsbi_cell: one slot of the stack row
// Holds one word; shifts from its neighbors or loads the pushed word.
// ---------------------------------------------------------------------------
module bsbi_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                               clk,
  input  bsbi_pkg::cell_ctrl_t               ctrl,
  input  logic [CNT_W-1:0]                   cnt,
  input  logic signed [bsbi_pkg::WORD_W-1:0] prev_val,
  input  logic signed [bsbi_pkg::WORD_W-1:0] next_val,
  input  logic signed [bsbi_pkg::WORD_W-1:0] push_value,
  output logic signed [bsbi_pkg::WORD_W-1:0] val
);
  import bsbi_pkg::*;

  logic signed [WORD_W-1:0] val_r;
  logic signed [WORD_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.push_top) begin
      val_nxt = prev_val;
    end else if (ctrl.pop) begin
      val_nxt = next_val;
    end else if (ctrl.push_bot && (cnt == CNT_W'(IDX))) begin
      // first free slot below the current bottom
      val_nxt = push_value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== src/bounded_stack_with_bottom_insert_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_stack_with_bottom_insert_unit: fixed-depth stack with bottom push
// Row of word cells with the top of the stack in cell 0, plus a fill count.
// ---------------------------------------------------------------------------
// Each accepted item is one operation: push on top, push at the bottom, pop
// or peek. The top word always sits in cell 0, so a push on top shifts the
// whole row down one cell, a pop shifts it up one cell, and a push at the
// bottom loads the first free cell (index equal to the fill count) with no
// shifting. Every cell updates in the same cycle from its neighbors, and an
// item's result is registered and shown on the out channel the cycle after
// it is accepted; a new item is accepted every cycle as long as the result
// register is empty or being drained. A push on a full stack is dropped with
// status full; a pop or peek on an empty stack returns -1 with status empty.
// fill_count and is_empty report the state after the operation. There is no
// clearing pass after reset: only the fill count and the output valid flag
// are reset, and cells are always written before they are read.
// ---------------------------------------------------------------------------
module bounded_stack_with_bottom_insert_unit #(
  parameter int DEPTH = bsbi_pkg::STK_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsbi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsbi_pkg::out_item_t out_data
);
  import bsbi_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         res;
  cell_ctrl_t        ctrl;
  logic              accept;
  logic              is_full;
  logic              is_mt;

  logic signed [WORD_W-1:0] cell_val [DEPTH];

  // Take a new item whenever the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_full = (cnt_r == CNT_W'(DEPTH));
  assign is_mt   = (cnt_r == '0);

  // Decode the operation into cell control and the result item
  always_comb begin
    ctrl           = '0;
    cnt_nxt        = cnt_r;
    res.read_value = '0;
    res.status     = ST_DONE;
    case (in_data.operation)
      OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          ctrl.push_top = accept && (in_data.operation == OP_PUSH_TOP);
          ctrl.push_bot = accept && (in_data.operation == OP_PUSH_BOTTOM);
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (is_mt) begin
          res.read_value = EMPTY_READ;
          res.status     = ST_EMPTY;
        end else begin
          res.read_value = cell_val[0];
          if (in_data.operation == OP_POP) begin
            ctrl.pop = accept;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
    res.fill_count = FILL_W'(cnt_nxt);
    res.is_empty   = (cnt_nxt == '0);
  end

  // Row of cells; cell 0 holds the top word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_v;
    logic signed [WORD_W-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = in_data.push_value;
    end else begin : g_mid_prev
      assign prev_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_mid_next
      assign next_v = cell_val[i+1];
    end

    bsbi_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cnt        (cnt_r),
      .prev_val   (prev_v),
      .next_val   (next_v),
      .push_value (in_data.push_value),
      .val        (cell_val[i])
    );
  end

  // Hold the result until it is taken; advance the count on accept
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("fill count moved without an item");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.operation == OP_POP) && !is_mt
    |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not lower fill count");

  a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (out_data_r.fill_count == '0)))
    else $error("empty flag disagrees with fill count");
`endif

endmodule

// ===== verif/stack_result_checker.sv =====
// ---------------------------------------------------------------------------
// stack_result_checker: result predictor and comparator for the stack unit
// Watches both channels, keeps its own copy of the stack, predicts one result
// per accepted item and compares every returned result field by field.
// ---------------------------------------------------------------------------
module stack_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bsbi_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bsbi_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_seen,
  output int                  full_drops,
  output int                  empty_reads
);
  import bsbi_pkg::*;

  // Shadow stack: slot 0 is the bottom, slot shadow_fill-1 the top
  logic signed [WORD_W-1:0] shadow_words [STK_DEPTH];
  int unsigned              shadow_fill;
  out_item_t                expected_results [$];

  task automatic predict_stack_op(input in_item_t item, output out_item_t res);
    int unsigned i;
    res = '0;
    res.status = ST_DONE;
    case (item.operation)
      OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
        if (shadow_fill == STK_DEPTH) begin
          res.status = ST_FULL;
        end else if (item.operation == OP_PUSH_TOP) begin
          shadow_words[shadow_fill] = item.push_value;
          shadow_fill++;
        end else begin
          for (i = shadow_fill; i > 0; i--) begin
            shadow_words[i] = shadow_words[i-1];
          end
          shadow_words[0] = item.push_value;
          shadow_fill++;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          res.read_value = EMPTY_READ;
          res.status     = ST_EMPTY;
        end else begin
          res.read_value = shadow_words[shadow_fill-1];
          if (item.operation == OP_POP) begin
            shadow_fill--;
          end
        end
      end
    endcase
    res.fill_count = FILL_W'(shadow_fill);
    res.is_empty   = (shadow_fill == 0);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      // Retire first: a result never belongs to the item accepted at this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: value %0d status %0d fill %0d empty %0b",
                     out_data.read_value, out_data.status, out_data.fill_count,
                     out_data.is_empty);
          end
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_value !== want.read_value || out_data.status !== want.status ||
              out_data.fill_count !== want.fill_count ||
              out_data.is_empty !== want.is_empty) begin
            if (mismatches < 10) begin
              $display("result %0d: expected value %0d status %0d fill %0d empty %0b",
                       results_seen, want.read_value, want.status, want.fill_count,
                       want.is_empty);
              $display("result %0d:      got value %0d status %0d fill %0d empty %0b",
                       results_seen, out_data.read_value, out_data.status,
                       out_data.fill_count, out_data.is_empty);
            end
            mismatches++;
          end
          results_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predict_stack_op(in_data, want);
        expected_results.push_back(want);
        if (want.status == ST_FULL) begin
          full_drops++;
        end
        if (want.status == ST_EMPTY) begin
          empty_reads++;
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb: top-level bench for bounded_stack_with_bottom_insert_unit
// Drives push, bottom push, pop and peek items with random gaps and stalls;
// a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
  import bsbi_pkg::*;

  localparam int RANDOM_ITEMS = 624;    // on top of the directed items
  localparam int LONG_HOLD    = 80;     // receiver hold-off that backs up the input
  localparam int TAIL_CYCLES  = 10;     // settle time after the last result
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches, outstanding, results_seen, full_drops, empty_reads;
  int cycle_count = 0;
  int items_sent = 0;
  bit long_hold_req = 1'b0;

  bounded_stack_with_bottom_insert_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  stack_result_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .full_drops   (full_drops),
    .empty_reads  (empty_reads)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: fail the run if it has not finished by the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
      $display("** bounded_stack_with_bottom_insert_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: mostly ready, short stalls, an occasional long one, and stretches
  // with no stall at all. A long hold-off requested by the sender side is
  // counted out here.
  initial begin : receiver
    int hold_left, steady_left, roll;
    hold_left   = 0;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
        steady_left   = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady_left > 0) begin
        steady_left--;
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          steady_left = $urandom_range(30, 120);
          out_ready <= 1'b1;
        end else if (roll < 7) begin
          hold_left = $urandom_range(10, 40) - 1;
          out_ready <= 1'b0;
        end else if (roll < 25) begin
          hold_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic send_item(input op_t op, input logic signed [WORD_W-1:0] word);
    in_item_t item;
    item.operation  = op;
    item.push_value = word;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold the input idle for the pause that n gives (n >= 1)
  task automatic pause_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold the input until every predicted result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int i, k, seg_len, segment, random_sent, roll, pick;
    bit no_idle;
    mix_t mode;
    op_t op;
    logic signed [WORD_W-1:0] word;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads on an empty stack, extreme words, every operation
    send_item(OP_POP, 32'sh1234_5678);
    send_item(OP_PEEK, 32'sh0);
    send_item(OP_PUSH_TOP, 32'sh7FFF_FFFF);
    send_item(OP_PUSH_BOTTOM, 32'sh8000_0000);
    send_item(OP_PEEK, 32'sh0);
    send_item(OP_POP, 32'sh0);
    pause_input(2);
    send_item(OP_POP, -32'sh1);
    send_item(OP_POP, 32'sh0);
    // Fill to the top with both pushes, then push twice more on a full stack
    for (i = 0; i < STK_DEPTH; i++) begin
      send_item((i % 2 == 0) ? OP_PUSH_BOTTOM : OP_PUSH_TOP, $urandom);
    end
    send_item(OP_PUSH_TOP, -32'sh1);
    send_item(OP_PUSH_BOTTOM, 32'sh5A5A_A5A5);
    wait_for_drain();

    // Random: segments that lean toward filling, draining or an even mix, so
    // the fill level keeps sweeping between empty and full
    random_sent = 0;
    segment     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 50);
      case ($urandom_range(0, 2))
        0:       mode = MODE_FILL;
        1:       mode = MODE_DRAIN;
        default: mode = MODE_MIXED;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      // Back up the block: receiver holds off while items keep coming
      if (segment == 2) begin
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
      end
      if (segment % 6 == 5) begin
        wait_for_drain();
      end
      for (k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          MODE_FILL: begin
            if (roll < 85) op = (roll % 2 == 0) ? OP_PUSH_TOP : OP_PUSH_BOTTOM;
            else           op = (roll % 2 == 0) ? OP_POP : OP_PEEK;
          end
          MODE_DRAIN: begin
            if (roll < 60)      op = OP_POP;
            else if (roll < 85) op = OP_PEEK;
            else                op = (roll % 2 == 0) ? OP_PUSH_TOP : OP_PUSH_BOTTOM;
          end
          default: begin
            case (roll % 4)
              0:       op = OP_PUSH_TOP;
              1:       op = OP_PUSH_BOTTOM;
              2:       op = OP_POP;
              default: op = OP_PEEK;
            endcase
          end
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
          0:       word = 32'sh7FFF_FFFF;
          1:       word = 32'sh8000_0000;
          2:       word = -32'sh1;
          3:       word = 32'sh0;
          default: word = $urandom;
        endcase
        send_item(op, word);
        random_sent++;
        if (!no_idle) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            pause_input($urandom_range(1, 3));
          end else if (roll < 10) begin
            pause_input($urandom_range(8, 30));
          end
        end
      end
      segment++;
    end

    // Drain, then give the block time to show any stray result
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items of all four operations over %0d cycles; %0d results checked.",
             items_sent, cycle_count, results_seen);
    $display("Pushes dropped on a full stack: %0d; reads on an empty stack: %0d.",
             full_drops, empty_reads);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** bounded_stack_with_bottom_insert_unit: PASSED **");
    end else begin
      $display("** bounded_stack_with_bottom_insert_unit: FAILED **");
    end
    $finish;
  end

endmodule
